// ===== hw/rtl/hmix_pkg.sv =====
// ----------------------------------------------------------------------------
// hmix_pkg: shared types and constants of the 64-bit byte-stream hash
// Job format between front and back end, back-end states, round shift table.
// ----------------------------------------------------------------------------
package hmix_pkg;

   localparam logic [63:0] GOLDEN_WORD = 64'h9e3779b97f4a7c13;
   localparam int          BLOCK_BYTES = 24;
   localparam int          BLOCK_W     = 8 * BLOCK_BYTES;
   localparam int          POS_W       = 5;
   localparam int          ROUNDS      = 12;
   localparam int          ROUND_W     = 4;

   // word that a mix round updates
   localparam logic [1:0] ROLE_A = 2'd0;
   localparam logic [1:0] ROLE_B = 2'd1;
   localparam logic [1:0] ROLE_C = 2'd2;

   typedef enum logic [1:0] {
      JOB_BLOCK,
      JOB_FINAL,
      JOB_BLOCK_FINAL
   } job_kind_type;

   typedef struct packed {
      job_kind_type kind;
      logic [63:0]  add_a;
      logic [63:0]  add_b;
      logic [63:0]  add_c;
      logic [63:0]  length;
   } mix_job_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MIX,
      BK_LEN,
      BK_DONE
   } back_state_type;

   function automatic logic [5:0] round_shift(input logic [ROUND_W-1:0] round);
      logic [5:0] sh;
      case (round)
         4'd0:    sh = 6'd43;
         4'd1:    sh = 6'd9;
         4'd2:    sh = 6'd8;
         4'd3:    sh = 6'd38;
         4'd4:    sh = 6'd23;
         4'd5:    sh = 6'd5;
         4'd6:    sh = 6'd35;
         4'd7:    sh = 6'd49;
         4'd8:    sh = 6'd11;
         4'd9:    sh = 6'd12;
         4'd10:   sh = 6'd18;
         4'd11:   sh = 6'd22;
         default: sh = 6'd0;
      endcase
      return sh;
   endfunction

   function automatic logic [1:0] round_role(input logic [ROUND_W-1:0] round);
      logic [1:0] role;
      case (round)
         4'd0, 4'd3, 4'd6, 4'd9:  role = ROLE_A;
         4'd1, 4'd4, 4'd7, 4'd10: role = ROLE_B;
         4'd2, 4'd5, 4'd8, 4'd11: role = ROLE_C;
         default:                 role = ROLE_A;
      endcase
      return role;
   endfunction

endpackage

// ===== hw/rtl/hmix_req_if.sv =====
// ----------------------------------------------------------------------------
// hmix_req_if: request channel of the byte-stream hash
// One message byte per request, with byte-valid and end-of-message flags.
// ----------------------------------------------------------------------------
interface hmix_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last;

   modport source (output valid, output data_byte, output byte_valid, output last,
                   input ready);
   modport sink   (input valid, input data_byte, input byte_valid, input last,
                   output ready);
endinterface

// ===== hw/rtl/hmix_rsp_if.sv =====
// ----------------------------------------------------------------------------
// hmix_rsp_if: response channel of the byte-stream hash
// Carries one 64-bit hash per finished message.
// ----------------------------------------------------------------------------
interface hmix_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_value;

   modport source (output valid, output hash_value, input ready);
   modport sink   (input valid, input hash_value, output ready);
endinterface

// ===== hw/rtl/hmix_front.sv =====
// ----------------------------------------------------------------------------
// hmix_front: byte packer
// Packs bytes into the 24-byte block, counts the length and issues mix jobs.
// ----------------------------------------------------------------------------
module hmix_front
   import hmix_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   input  logic        req_byte_valid,
   input  logic        req_last,
   input  logic        job_full,
   output logic        job_push,
   output mix_job_type job_out
);

   logic [BLOCK_W-1:0] blk_ff, blk_in, blk_next, blk_ins;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [63:0]        len_ff, len_in, len_next;
   logic               accept, blk_full;

   assign req_ready = !job_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      blk_ins  = {{(BLOCK_W-8){1'b0}}, req_data_byte} << {pos_ff, 3'b000};
      blk_next = req_byte_valid ? (blk_ff | blk_ins) : blk_ff;
      len_next = len_ff + 64'(req_byte_valid);
      blk_full = req_byte_valid && (pos_ff == POS_W'(BLOCK_BYTES - 1));

      job_out.add_a  = blk_next[63:0];
      job_out.add_b  = blk_next[127:64];
      job_out.length = len_next;
      if (req_last && !blk_full) begin
         // tail: third-word bytes sit one byte higher, length joins them
         job_out.kind  = JOB_FINAL;
         job_out.add_c = {blk_next[183:128], 8'h00} + len_next;
      end else if (req_last) begin
         job_out.kind  = JOB_BLOCK_FINAL;
         job_out.add_c = blk_next[191:128];
      end else begin
         job_out.kind  = JOB_BLOCK;
         job_out.add_c = blk_next[191:128];
      end
      job_push = accept && (blk_full || req_last);

      blk_in = blk_ff;
      pos_in = pos_ff;
      len_in = len_ff;
      if (csr_we) begin
         blk_in = '0;
         pos_in = '0;
         len_in = '0;
      end else if (accept) begin
         if (req_last) begin
            blk_in = '0;
            pos_in = '0;
            len_in = '0;
         end else if (blk_full) begin
            blk_in = '0;
            pos_in = '0;
            len_in = len_next;
         end else if (req_byte_valid) begin
            blk_in = blk_next;
            pos_in = pos_ff + POS_W'(1);
            len_in = len_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         blk_ff <= '0;
         pos_ff <= '0;
         len_ff <= '0;
      end else begin
         blk_ff <= blk_in;
         pos_ff <= pos_in;
         len_ff <= len_in;
      end
   end

endmodule

// ===== hw/rtl/hmix_queue.sv =====
// ----------------------------------------------------------------------------
// hmix_queue: job queue
// Small first-in first-out store of mix jobs between front and back end.
// ----------------------------------------------------------------------------
module hmix_queue
   import hmix_pkg::*;
#(
   parameter int DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   input  mix_job_type push_job,
   output logic        full,
   input  logic        pop,
   output mix_job_type pop_job,
   output logic        not_empty
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mix_job_type      store_ff [DEPTH];
   logic [IDX_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign pop_job   = store_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + IDX_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + IDX_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_job;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// ===== hw/rtl/hmix_back.sv =====
// ----------------------------------------------------------------------------
// hmix_back: mixing engine
// Holds the three hash words, runs one subtract-xor-shift round per cycle,
// and drives the registered hash output.
// ----------------------------------------------------------------------------
module hmix_back
   import hmix_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [63:0] csr_wdata,
   input  logic        job_avail,
   input  mix_job_type job_in,
   output logic        job_pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_hash_value
);

   back_state_type     state_ff, state_in;
   job_kind_type       kind_ff, kind_in;
   logic [ROUND_W-1:0] round_ff, round_in;
   logic [63:0]        seed_ff, len_ff, len_in;
   logic [63:0]        word_a_ff, word_a_in, word_b_ff, word_b_in, word_c_ff, word_c_in;
   logic [63:0]        hash_ff, hash_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic               out_free, last_round;
   logic [1:0]         role;
   logic [5:0]         shift;
   logic [63:0]        mx, mp, mq, mdiff, mnew;

   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign last_round     = (round_ff == ROUND_W'(ROUNDS - 1));
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_hash_value = hash_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job_avail) begin
               state_in = BK_MIX;
            end
         end
         BK_MIX: begin
            if (last_round) begin
               case (kind_ff)
                  JOB_FINAL:       state_in = BK_DONE;
                  JOB_BLOCK_FINAL: state_in = BK_LEN;
                  default:         state_in = BK_IDLE;
               endcase
            end
         end
         BK_LEN:  state_in = BK_MIX;
         BK_DONE: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
      if (csr_we) begin
         state_in = BK_IDLE;
      end
   end

   // one mix round: x = (x - p - q) ^ shift(q)
   always_comb begin
      role  = round_role(round_ff);
      shift = round_shift(round_ff);
      case (role)
         ROLE_B: begin
            mx = word_b_ff;
            mp = word_c_ff;
            mq = word_a_ff;
         end
         ROLE_C: begin
            mx = word_c_ff;
            mp = word_a_ff;
            mq = word_b_ff;
         end
         default: begin
            mx = word_a_ff;
            mp = word_b_ff;
            mq = word_c_ff;
         end
      endcase
      mdiff = mx - mp - mq;
      mnew  = mdiff ^ ((role == ROLE_B) ? (mq << shift) : (mq >> shift));
   end

   // datapath and outputs
   always_comb begin
      job_pop      = 1'b0;
      word_a_in    = word_a_ff;
      word_b_in    = word_b_ff;
      word_c_in    = word_c_ff;
      kind_in      = kind_ff;
      len_in       = len_ff;
      round_in     = round_ff;
      hash_in      = hash_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         BK_IDLE: begin
            if (job_avail) begin
               job_pop   = 1'b1;
               word_a_in = word_a_ff + job_in.add_a;
               word_b_in = word_b_ff + job_in.add_b;
               word_c_in = word_c_ff + job_in.add_c;
               kind_in   = job_in.kind;
               len_in    = job_in.length;
               round_in  = '0;
            end
         end
         BK_MIX: begin
            case (role)
               ROLE_B:  word_b_in = mnew;
               ROLE_C:  word_c_in = mnew;
               default: word_a_in = mnew;
            endcase
            round_in = last_round ? '0 : round_ff + ROUND_W'(1);
         end
         BK_LEN: begin
            word_c_in = word_c_ff + len_ff;
            kind_in   = JOB_FINAL;
         end
         BK_DONE: begin
            if (out_free) begin
               hash_in      = word_c_ff;
               rsp_valid_in = 1'b1;
               // restart words for the next message
               word_a_in    = seed_ff;
               word_b_in    = seed_ff;
               word_c_in    = GOLDEN_WORD;
            end
         end
         default: ;
      endcase
      if (csr_we) begin
         job_pop   = 1'b0;
         word_a_in = csr_wdata;
         word_b_in = csr_wdata;
         word_c_in = GOLDEN_WORD;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         round_ff     <= '0;
         kind_ff      <= JOB_BLOCK;
         rsp_valid_ff <= 1'b0;
         seed_ff      <= '0;
         word_a_ff    <= '0;
         word_b_ff    <= '0;
         word_c_ff    <= GOLDEN_WORD;
      end else begin
         state_ff     <= state_in;
         round_ff     <= round_in;
         kind_ff      <= kind_in;
         rsp_valid_ff <= rsp_valid_in;
         word_a_ff    <= word_a_in;
         word_b_ff    <= word_b_in;
         word_c_ff    <= word_c_in;
         if (csr_we) begin
            seed_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      hash_ff <= hash_in;
   end

endmodule

// ===== hw/rtl/hash64_mix_byte_stream.sv =====
// ----------------------------------------------------------------------------
// hash64_mix_byte_stream: 64-bit byte-stream hash (lookup8 style)
// Byte packer, job queue and mixing engine with registered hash output.
// ----------------------------------------------------------------------------
// Takes one message byte per request at up to one request per cycle and
// returns the 64-bit hash from the engine's registered output. Requests are
// taken as long as the job queue (QUEUE_DEPTH jobs) has room; each completed
// 24-byte block or message end becomes one job, a single one if the final
// byte closes a block. The engine runs one subtract-xor-shift round per
// cycle: a block costs it a load and 12 rounds, a message end a load, 12
// rounds and an output step, plus a length step and 12 more rounds if the
// final byte closes a block; it takes a new job only from idle. Long
// messages stream at one byte per cycle while the queue has room. A seed
// write through csr_we restarts the message with the new seed and must only occur while idle.
module hash64_mix_byte_stream
   import hmix_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
)
(
   input  logic        clock,
   input  logic        reset,
   hmix_req_if.sink    req_chan,
   hmix_rsp_if.source  rsp_chan,
   input  logic        csr_we,
   input  logic [63:0] csr_wdata
);

   mix_job_type push_job, pop_job;
   logic        job_push, job_full, job_pop, job_avail;

   hmix_front u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .req_valid      (req_chan.valid),
      .req_ready      (req_chan.ready),
      .req_data_byte  (req_chan.data_byte),
      .req_byte_valid (req_chan.byte_valid),
      .req_last       (req_chan.last),
      .job_full       (job_full),
      .job_push       (job_push),
      .job_out        (push_job)
   );

   hmix_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (push_job),
      .full      (job_full),
      .pop       (job_pop),
      .pop_job   (pop_job),
      .not_empty (job_avail)
   );

   hmix_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_wdata      (csr_wdata),
      .job_avail      (job_avail),
      .job_in         (pop_job),
      .job_pop        (job_pop),
      .rsp_valid      (rsp_chan.valid),
      .rsp_ready      (rsp_chan.ready),
      .rsp_hash_value (rsp_chan.hash_value)
   );

endmodule

// ===== hw/rtl/hmix_checker.sv =====
// ----------------------------------------------------------------------------
// hmix_checker: port-level checks of the byte-stream hash
// Watches the request and response handshakes of the top level.
// ----------------------------------------------------------------------------
module hmix_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_last,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_hash_value
);

   logic [15:0] pending_ff, pending_in;
   logic        end_taken, rsp_taken;

   assign end_taken = req_valid && req_ready && req_last;
   assign rsp_taken = rsp_valid && rsp_ready;

   always_comb begin
      pending_in = pending_ff;
      if (end_taken && !rsp_taken) begin
         pending_in = pending_ff + 16'd1;
      end else if (rsp_taken && !end_taken) begin
         pending_in = pending_ff - 16'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // a hash only follows an accepted end of message
   a_rsp_has_cause: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (pending_ff != 16'd0))
      else $error("response without a pending end-of-message request");

   a_idle_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_hash_value))
      else $error("hash changed while stalled");

endmodule

bind hash64_mix_byte_stream hmix_checker u_hmix_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_chan.valid),
   .req_ready      (req_chan.ready),
   .req_last       (req_chan.last),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_hash_value (rsp_chan.hash_value)
);
